// File: src/spt_pkg.sv
// Package for the sorted point table: shared codes, fixed field widths and the
// control structs that the sequencer passes to the scan unit and the merge unit.
// No dependencies.
`default_nettype none

package spt_pkg;

    localparam int SLOT_W     = 6;
    localparam int IN_POS_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int COUNT_W    = 7;
    localparam int MAXLEN_W   = 17;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 17'h10000;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_SET    = 3'd2,
        REQ_MOVE   = 3'd3,
        REQ_FIND   = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        REG_MAX_LENGTH      = 2'd0,
        REG_SIZE_LOCKED     = 2'd1,
        REG_VALUE_LOCKED    = 2'd2,
        REG_POSITION_LOCKED = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_BUILD,
        ST_DONE
    } state_t;

    // Controls for the scan unit at the head of the chain.
    typedef struct packed {
        logic clear;    // start of a transaction: reset the running results
        logic step;     // a table entry is at the head this cycle
        logic live;     // that entry lies below the point count
        logic at_slot;  // that entry is the requested slot
        logic skip_en;  // leave the requested slot out of the rank count
    } scan_ctrl_t;

    // Controls for the write-back merge at the tail of the chain.
    typedef struct packed {
        logic del_en;   // drop the requested slot from the stream
        logic ins_en;   // put the new point into the stream
        logic lvl_en;   // overwrite the level of the requested slot
    } merge_ctrl_t;

endpackage

`default_nettype wire

// File: src/spt_if.sv
// Request and response channel interfaces of the sorted point table.
// Depends on spt_pkg for the payload widths.
`default_nettype none

interface spt_req_if import spt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [2:0]                req_type;
    logic [IN_POS_W-1:0]       position;
    logic [SLOT_W-1:0]         slot;
    logic signed [LEVEL_W-1:0] level;

    modport source (output valid, output req_type, output position, output slot,
                    output level, input ready);
    modport sink   (input valid, input req_type, input position, input slot,
                    input level, output ready);
endinterface

interface spt_rsp_if import spt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [SLOT_W-1:0]         result_slot;
    logic                      exact_hit;
    logic [IN_POS_W-1:0]       hit_position;
    logic signed [LEVEL_W-1:0] hit_level;
    logic [COUNT_W-1:0]        point_count;

    modport source (output valid, output accepted, output result_slot, output exact_hit,
                    output hit_position, output hit_level, output point_count,
                    input ready);
    modport sink   (input valid, input accepted, input result_slot, input exact_hit,
                    input hit_position, input hit_level, input point_count,
                    output ready);
endinterface

`default_nettype wire

// File: src/sorted_point_table.sv
// Sorted point table, top level. A request is taken only while idle. Each request
// makes a SCAN pass, a DECIDE step, a BUILD pass for accepted edits and a DONE step;
// a pass is one full trip of the data around the cell chain. A new request is taken
// only once the last one has loaded its response and the sequencer is idle again.
// rst_n is asynchronous, active low: it empties the table (count zero) and loads the
// register reset values; point storage itself is not cleared.
`default_nettype none

module sorted_point_table import spt_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int POS_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    spt_req_if.sink                    req,
    spt_rsp_if.source                  rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // ------------------------------------------------------------------
    // Configuration registers. Writes complete in the APB access phase;
    // pready is tied high so there are no wait states.
    // ------------------------------------------------------------------
    logic [MAXLEN_W-1:0] max_length_reg;
    logic                size_locked_reg;
    logic                value_locked_reg;
    logic                position_locked_reg;
    logic                cfg_wr;
    reg_index_t          cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg      <= MAXLEN_RESET;
            size_locked_reg     <= 1'b0;
            value_locked_reg    <= 1'b0;
            position_locked_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_MAX_LENGTH:      max_length_reg      <= pwdata[MAXLEN_W-1:0];
                REG_SIZE_LOCKED:     size_locked_reg     <= pwdata[0];
                REG_VALUE_LOCKED:    value_locked_reg    <= pwdata[0];
                REG_POSITION_LOCKED: position_locked_reg <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_MAX_LENGTH:      prdata = APB_DATA_W'(max_length_reg);
            REG_SIZE_LOCKED:     prdata = APB_DATA_W'(size_locked_reg);
            REG_VALUE_LOCKED:    prdata = APB_DATA_W'(value_locked_reg);
            REG_POSITION_LOCKED: prdata = APB_DATA_W'(position_locked_reg);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request capture. The incoming position is cut to POS_BITS bits.
    // ------------------------------------------------------------------
    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [2:0]          req_type_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [LEVEL_W-1:0]  lvl_reg;
    logic                req_fire;
    logic                pass_end;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign pass_end  = (idx_reg == IDX_W'(CAPACITY - 1));

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_type_reg <= req.req_type;
            pos_reg      <= POS_BITS'(req.position);
            slot_reg     <= req.slot;
            lvl_reg      <= req.level;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. In every SCAN or BUILD cycle each cell takes the contents
    // of its right neighbor, so entry k of the table sits in cell 0 while
    // the pass index is k. The tail cell takes the write-back value from the
    // merge unit: during SCAN that is the head itself, so a full pass leaves
    // the table as it was; during BUILD it is the edited table stream.
    // ------------------------------------------------------------------
    logic [POS_BITS-1:0] cell_pos  [CAPACITY];
    logic [LEVEL_W-1:0]  cell_lvl  [CAPACITY];
    logic [POS_BITS-1:0] feed_pos  [CAPACITY];
    logic [LEVEL_W-1:0]  feed_lvl  [CAPACITY];
    logic [POS_BITS-1:0] wb_pos;
    logic [LEVEL_W-1:0]  wb_lvl;
    logic                chain_shift;

    assign chain_shift = (state_reg == ST_SCAN) || (state_reg == ST_BUILD);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == CAPACITY - 1)
        begin : g_tail
            assign feed_pos[i] = wb_pos;
            assign feed_lvl[i] = wb_lvl;
        end
        else
        begin : g_body
            assign feed_pos[i] = cell_pos[i+1];
            assign feed_lvl[i] = cell_lvl[i+1];
        end

        spt_cell #(
            .POS_BITS (POS_BITS)
        ) u_cell (
            .clk     (clk),
            .shift   (chain_shift),
            .nxt_pos (feed_pos[i]),
            .nxt_lvl (feed_lvl[i]),
            .pos     (cell_pos[i]),
            .lvl     (cell_lvl[i])
        );
    end

    // ------------------------------------------------------------------
    // Scan unit: during the SCAN pass it looks at the head entry each
    // cycle and keeps the nearest point (ties to the lower index), the
    // number of points below the target position, and the requested slot.
    // ------------------------------------------------------------------
    scan_ctrl_t          scan_ctl;
    logic [IDX_W-1:0]    near_idx;
    logic                near_exact;
    logic [POS_BITS-1:0] near_pos;
    logic [LEVEL_W-1:0]  near_lvl;
    logic [CNT_W-1:0]    rank;
    logic [POS_BITS-1:0] slot_pos;
    logic [LEVEL_W-1:0]  slot_lvl;

    always_comb
    begin
        scan_ctl.clear   = req_fire;
        scan_ctl.step    = (state_reg == ST_SCAN);
        scan_ctl.live    = 32'(idx_reg) < 32'(count_reg);
        scan_ctl.at_slot = 32'(idx_reg) == 32'(slot_reg);
        scan_ctl.skip_en = (req_type_reg == REQ_MOVE);
    end

    spt_scan #(
        .CAPACITY (CAPACITY),
        .POS_BITS (POS_BITS)
    ) u_scan (
        .clk        (clk),
        .ctl        (scan_ctl),
        .head_idx   (idx_reg),
        .head_pos   (cell_pos[0]),
        .head_lvl   (cell_lvl[0]),
        .target     (pos_reg),
        .near_idx   (near_idx),
        .near_exact (near_exact),
        .near_pos   (near_pos),
        .near_lvl   (near_lvl),
        .rank       (rank),
        .slot_pos   (slot_pos),
        .slot_lvl   (slot_lvl)
    );

    // ------------------------------------------------------------------
    // Decision. After the scan pass every answer is known: the response
    // fields, the new point count and how the table must be rebuilt.
    // A move is a removal followed by an insertion at the rank counted
    // without the moving point, done in the same BUILD pass.
    // ------------------------------------------------------------------
    logic                in_range;
    logic                slot_ok;
    logic                table_full;
    logic                res_acc_next;
    logic [SLOT_W-1:0]   res_slot_next;
    logic                res_exact_next;
    logic [POS_BITS-1:0] res_pos_next;
    logic [LEVEL_W-1:0]  res_lvl_next;
    merge_ctrl_t         edit_next;
    logic [IDX_W-1:0]    ins_idx_next;
    logic [LEVEL_W-1:0]  new_lvl_next;

    always_comb
    begin
        in_range   = 32'(pos_reg) < 32'(max_length_reg);
        slot_ok    = 32'(slot_reg) < 32'(count_reg);
        table_full = (count_reg == CNT_W'(CAPACITY));

        res_acc_next   = 1'b0;
        res_slot_next  = '0;
        res_exact_next = 1'b0;
        res_pos_next   = '0;
        res_lvl_next   = '0;
        edit_next      = '0;
        ins_idx_next   = '0;
        new_lvl_next   = '0;
        count_next     = count_reg;

        unique case (req_type_reg)
            REQ_ADD:
            begin
                if (in_range)
                begin
                    if (near_exact || size_locked_reg || table_full)
                    begin
                        // Refused: report the nearest point, zeros on an empty table.
                        res_slot_next  = SLOT_W'(near_idx);
                        res_exact_next = near_exact;
                        res_pos_next   = near_pos;
                        res_lvl_next   = near_lvl;
                    end
                    else
                    begin
                        res_acc_next     = 1'b1;
                        res_slot_next    = SLOT_W'(rank);
                        res_pos_next     = pos_reg;
                        edit_next.ins_en = 1'b1;
                        ins_idx_next     = IDX_W'(rank);
                        count_next       = count_reg + 1'b1;
                    end
                end
            end
            REQ_DELETE:
            begin
                // The slot capture is zero unless the slot holds a point.
                res_slot_next = slot_reg;
                res_pos_next  = slot_pos;
                res_lvl_next  = slot_lvl;
                if (!size_locked_reg && slot_ok)
                begin
                    res_acc_next     = 1'b1;
                    edit_next.del_en = 1'b1;
                    count_next       = count_reg - 1'b1;
                end
            end
            REQ_SET:
            begin
                res_slot_next = slot_reg;
                res_pos_next  = slot_pos;
                res_lvl_next  = slot_lvl;
                if (!value_locked_reg && slot_ok)
                begin
                    res_acc_next     = 1'b1;
                    res_lvl_next     = lvl_reg;
                    edit_next.lvl_en = 1'b1;
                    new_lvl_next     = lvl_reg;
                end
            end
            REQ_MOVE:
            begin
                res_slot_next = slot_reg;
                res_pos_next  = slot_pos;
                res_lvl_next  = slot_lvl;
                if (!position_locked_reg && slot_ok && in_range)
                begin
                    if (near_exact)
                    begin
                        // Something already sits there, possibly the point itself.
                        res_exact_next = 1'b1;
                    end
                    else
                    begin
                        res_acc_next     = 1'b1;
                        res_slot_next    = SLOT_W'(rank);
                        res_pos_next     = pos_reg;
                        edit_next.del_en = 1'b1;
                        edit_next.ins_en = 1'b1;
                        ins_idx_next     = IDX_W'(rank);
                        new_lvl_next     = slot_lvl;
                    end
                end
            end
            REQ_FIND:
            begin
                if (in_range && (count_reg != '0))
                begin
                    res_acc_next   = 1'b1;
                    res_slot_next  = SLOT_W'(near_idx);
                    res_exact_next = near_exact;
                    res_pos_next   = near_pos;
                    res_lvl_next   = near_lvl;
                end
            end
            default:
            begin
                // Unknown request codes are ignored.
            end
        endcase
    end

    // Decision results held for the BUILD pass and the response stage.
    logic                res_acc_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_exact_reg;
    logic [POS_BITS-1:0] res_pos_reg;
    logic [LEVEL_W-1:0]  res_lvl_reg;
    merge_ctrl_t         edit_reg;
    logic [IDX_W-1:0]    ins_idx_reg;
    logic [LEVEL_W-1:0]  new_lvl_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
        begin
            res_acc_reg   <= res_acc_next;
            res_slot_reg  <= res_slot_next;
            res_exact_reg <= res_exact_next;
            res_pos_reg   <= res_pos_next;
            res_lvl_reg   <= res_lvl_next;
            ins_idx_reg   <= ins_idx_next;
            new_lvl_reg   <= new_lvl_next;
        end
    end

    // ------------------------------------------------------------------
    // Merge unit: builds the write-back stream for the tail cell.
    // Outside BUILD it passes the head straight through.
    // ------------------------------------------------------------------
    merge_ctrl_t merge_ctl;

    assign merge_ctl = (state_reg == ST_BUILD) ? edit_reg : '0;

    spt_merge #(
        .CAPACITY (CAPACITY),
        .POS_BITS (POS_BITS)
    ) u_merge (
        .clk        (clk),
        .ctl        (merge_ctl),
        .idx        (idx_reg),
        .slot_idx   (slot_reg),
        .ins_idx    (ins_idx_reg),
        .new_pos    (pos_reg),
        .new_lvl    (new_lvl_reg),
        .head_pos   (cell_pos[0]),
        .head_lvl   (cell_lvl[0]),
        .second_pos (cell_pos[1]),
        .second_lvl (cell_lvl[1]),
        .wb_pos     (wb_pos),
        .wb_lvl     (wb_lvl)
    );

    // ------------------------------------------------------------------
    // Sequencer: IDLE -> SCAN -> DECIDE -> (BUILD) -> DONE -> IDLE.
    // DONE waits until the response register is free.
    // ------------------------------------------------------------------
    logic rsp_valid_reg;
    logic rsp_load;

    always_comb
    begin
        state_next = state_reg;
        rsp_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pass_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (edit_next != '0)
                begin
                    state_next = ST_BUILD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BUILD:
            begin
                if (pass_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
            edit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (chain_shift && !pass_end)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            else
            begin
                idx_reg <= '0;
            end
            if (state_reg == ST_DECIDE)
            begin
                count_reg <= count_next;
                edit_reg  <= edit_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response register. A finished transaction is parked here so that the
    // consumer may stall without holding up the sequencer's bookkeeping.
    // ------------------------------------------------------------------
    logic                rsp_acc_reg;
    logic [SLOT_W-1:0]   rsp_slot_reg;
    logic                rsp_exact_reg;
    logic [IN_POS_W-1:0] rsp_pos_reg;
    logic [LEVEL_W-1:0]  rsp_lvl_reg;
    logic [COUNT_W-1:0]  rsp_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_acc_reg   <= res_acc_reg;
            rsp_slot_reg  <= res_slot_reg;
            rsp_exact_reg <= res_exact_reg;
            rsp_pos_reg   <= IN_POS_W'(res_pos_reg);
            rsp_lvl_reg   <= res_lvl_reg;
            rsp_count_reg <= COUNT_W'(count_reg);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.accepted     = rsp_acc_reg;
    assign rsp.result_slot  = rsp_slot_reg;
    assign rsp.exact_hit    = rsp_exact_reg;
    assign rsp.hit_position = rsp_pos_reg;
    assign rsp.hit_level    = rsp_lvl_reg;
    assign rsp.point_count  = rsp_count_reg;

`ifndef SYNTHESIS
    // An accepted request always starts a scan pass at the head of the table.
    a_fire_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_SCAN) && (idx_reg == '0))
        else $error("request transaction did not start a scan pass");

    // A response appears only as the sequencer leaves DONE.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the DONE state");

    // One transaction changes the point count by at most one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |=> (count_reg == $past(count_reg))
            || (count_reg == $past(count_reg) + 1'b1)
            || (count_reg + 1'b1 == $past(count_reg)))
        else $error("point count moved by more than one");

    // The table never holds more points than cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |=> (count_reg <= CNT_W'(CAPACITY)))
        else $error("point count exceeds capacity");
`endif

endmodule

`default_nettype wire

// File: src/spt_cell.sv
// One storage cell of the point chain: a position and a level that move one
// place toward the head whenever the chain shifts. Depends on spt_pkg.
`default_nettype none

module spt_cell import spt_pkg::*;
#(
    parameter int POS_BITS = 16
)
(
    input  wire logic                clk,
    input  wire logic                shift,
    input  wire logic [POS_BITS-1:0] nxt_pos,
    input  wire logic [LEVEL_W-1:0]  nxt_lvl,
    output logic      [POS_BITS-1:0] pos,
    output logic      [LEVEL_W-1:0]  lvl
);

    logic [POS_BITS-1:0] pos_reg;
    logic [LEVEL_W-1:0]  lvl_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            pos_reg <= nxt_pos;
            lvl_reg <= nxt_lvl;
        end
    end

    assign pos = pos_reg;
    assign lvl = lvl_reg;

endmodule

`default_nettype wire

// File: src/spt_scan.sv
// Scan unit at the head of the point chain: tracks the nearest point, the rank
// of the target position and the contents of the requested slot. Depends on spt_pkg.
`default_nettype none

module spt_scan import spt_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int POS_BITS = 16
)
(
    input  wire logic                                 clk,
    input  wire scan_ctrl_t                           ctl,
    input  wire logic [$clog2(CAPACITY)-1:0]          head_idx,
    input  wire logic [POS_BITS-1:0]                  head_pos,
    input  wire logic [LEVEL_W-1:0]                   head_lvl,
    input  wire logic [POS_BITS-1:0]                  target,
    output logic      [$clog2(CAPACITY)-1:0]          near_idx,
    output logic                                      near_exact,
    output logic      [POS_BITS-1:0]                  near_pos,
    output logic      [LEVEL_W-1:0]                   near_lvl,
    output logic      [$clog2(CAPACITY+1)-1:0]        rank,
    output logic      [POS_BITS-1:0]                  slot_pos,
    output logic      [LEVEL_W-1:0]                   slot_lvl
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [POS_BITS:0]   best_d_reg;
    logic [IDX_W-1:0]    near_idx_reg;
    logic [POS_BITS-1:0] near_pos_reg;
    logic [LEVEL_W-1:0]  near_lvl_reg;
    logic [CNT_W-1:0]    rank_reg;
    logic [POS_BITS-1:0] slot_pos_reg;
    logic [LEVEL_W-1:0]  slot_lvl_reg;

    logic [POS_BITS-1:0] gap;
    logic                closer;

    always_comb
    begin
        gap    = (head_pos >= target) ? (head_pos - target) : (target - head_pos);
        // Strictly closer only, so ties stay with the lower index.
        closer = {1'b0, gap} < best_d_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            best_d_reg   <= '1;
            near_idx_reg <= '0;
            near_pos_reg <= '0;
            near_lvl_reg <= '0;
            rank_reg     <= '0;
            slot_pos_reg <= '0;
            slot_lvl_reg <= '0;
        end
        else if (ctl.step && ctl.live)
        begin
            if (closer)
            begin
                best_d_reg   <= {1'b0, gap};
                near_idx_reg <= head_idx;
                near_pos_reg <= head_pos;
                near_lvl_reg <= head_lvl;
            end
            if (!(ctl.skip_en && ctl.at_slot) && (head_pos < target))
            begin
                rank_reg <= rank_reg + 1'b1;
            end
            if (ctl.at_slot)
            begin
                slot_pos_reg <= head_pos;
                slot_lvl_reg <= head_lvl;
            end
        end
    end

    assign near_idx   = near_idx_reg;
    assign near_exact = (best_d_reg == '0);
    assign near_pos   = near_pos_reg;
    assign near_lvl   = near_lvl_reg;
    assign rank       = rank_reg;
    assign slot_pos   = slot_pos_reg;
    assign slot_lvl   = slot_lvl_reg;

endmodule

`default_nettype wire

// File: src/spt_merge.sv
// Write-back merge at the tail of the point chain: rebuilds the table stream
// with one point dropped, inserted, moved or relabeled. Depends on spt_pkg.
`default_nettype none

module spt_merge import spt_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int POS_BITS = 16
)
(
    input  wire logic                        clk,
    input  wire merge_ctrl_t                 ctl,
    input  wire logic [$clog2(CAPACITY)-1:0] idx,
    input  wire logic [SLOT_W-1:0]           slot_idx,
    input  wire logic [$clog2(CAPACITY)-1:0] ins_idx,
    input  wire logic [POS_BITS-1:0]         new_pos,
    input  wire logic [LEVEL_W-1:0]          new_lvl,
    input  wire logic [POS_BITS-1:0]         head_pos,
    input  wire logic [LEVEL_W-1:0]          head_lvl,
    input  wire logic [POS_BITS-1:0]         second_pos,
    input  wire logic [LEVEL_W-1:0]          second_lvl,
    output logic      [POS_BITS-1:0]         wb_pos,
    output logic      [LEVEL_W-1:0]          wb_lvl
);

    logic [POS_BITS-1:0] carry_pos_reg;
    logic [LEVEL_W-1:0]  carry_lvl_reg;
    logic [POS_BITS-1:0] r_pos;
    logic [LEVEL_W-1:0]  r_lvl;

    always_comb
    begin
        // Stream with the requested slot removed: from that slot on the entry
        // one place behind the head is the one to keep.
        if (ctl.del_en && (32'(idx) >= 32'(slot_idx)))
        begin
            r_pos = second_pos;
            r_lvl = second_lvl;
        end
        else
        begin
            r_pos = head_pos;
            r_lvl = head_lvl;
        end
        if (ctl.lvl_en && (32'(idx) == 32'(slot_idx)))
        begin
            r_lvl = new_lvl;
        end

        // Insertion delays the rest of the stream by one entry.
        if (ctl.ins_en && (idx == ins_idx))
        begin
            wb_pos = new_pos;
            wb_lvl = new_lvl;
        end
        else if (ctl.ins_en && (idx > ins_idx))
        begin
            wb_pos = carry_pos_reg;
            wb_lvl = carry_lvl_reg;
        end
        else
        begin
            wb_pos = r_pos;
            wb_lvl = r_lvl;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_pos_reg <= r_pos;
        carry_lvl_reg <= r_lvl;
    end

endmodule

`default_nettype wire
